>>> hdl/incpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incpid_pkg
// Shared types and constants of the incremental PID speed loop.
// ----------------------------------------------------------------------------
package incpid_pkg;

    // Field widths
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 18;   // stored error history width
    localparam int DRIVE_W = 10;
    localparam int CFG_IDX_W = 2;

    // Drive range and gain scale (gains are in thousandths)
    localparam int DRIVE_MAX  = 1000;
    localparam int GAIN_SCALE = 1000;

    // Accumulator width: sum of three gain*error products, signed
    localparam int ACC_W = 38;

    // Any |acc| at or above this limit gives |increment| > DRIVE_MAX, which
    // saturates the drive the same way, so magnitudes are clamped to it.
    localparam int ACC_LIMIT = (DRIVE_MAX + 1) * GAIN_SCALE;
    localparam int MAG_W     = $clog2(ACC_LIMIT + 1);

    // Reciprocal for floor(mag / GAIN_SCALE): exact for every mag <= ACC_LIMIT
    localparam int DIV_SHIFT = 30;
    localparam longint DIV_RECIP = ((64'd1 << DIV_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int QUOT_W    = $clog2(DRIVE_MAX + 2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_RESET  = 16'd0;
    localparam logic [GAIN_W-1:0] INTEG_RESET = 16'd500;
    localparam logic [GAIN_W-1:0] DERIV_RESET = 16'd0;

    // Gain set handed to the error stage
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    // Item between the error stage and the drive stage
    typedef struct packed {
        logic             ch;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_acc_item;

endpackage

>>> hdl/incpid_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incpid_cfg
// Gain register file written through the configuration channel.
// ----------------------------------------------------------------------------
module incpid_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [incpid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [incpid_pkg::GAIN_W-1:0]    i_cfg_data,
    output incpid_pkg::t_gains               o_gains
);
    import incpid_pkg::*;

    t_gains r_gains;

    // Register writes; an unlisted index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp <= PROP_RESET;
            r_gains.ki <= INTEG_RESET;
            r_gains.kd <= DERIV_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP:  r_gains.kp <= i_cfg_data;
                CFG_INTEG: r_gains.ki <= i_cfg_data;
                CFG_DERIV: r_gains.kd <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign o_gains = r_gains;

endmodule

>>> hdl/incpid_err.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incpid_err
// Input register, error history and PID sum; hands a clamped magnitude on.
// ----------------------------------------------------------------------------
module incpid_err (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  incpid_pkg::t_gains                    i_gains,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_channel,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_target_speed,
    output logic                                  o_acc_valid,
    input  logic                                  i_acc_take,
    output incpid_pkg::t_acc_item                 o_acc
);
    import incpid_pkg::*;

    // Input register
    logic                      r_a_valid;
    logic                      r_a_ch;
    logic signed [SPEED_W-1:0] r_a_meas;
    logic signed [SPEED_W-1:0] r_a_targ;

    // Per-channel error history
    logic signed [ERR_W-1:0] r_last_err  [2];
    logic signed [ERR_W-1:0] r_prior_err [2];

    // Stage register toward the drive stage
    logic      r_b_valid;
    t_acc_item r_b;

    logic en_b;
    logic en_a;

    logic signed [SPEED_W:0]   e;
    logic signed [ERR_W-1:0]   e1;
    logic signed [ERR_W-1:0]   e2;
    logic signed [ERR_W:0]     de1;
    logic signed [ERR_W+1:0]   de2;
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    ki_s;
    logic signed [GAIN_W:0]    kd_s;
    logic signed [ACC_W-1:0]   prod_p;
    logic signed [ACC_W-1:0]   prod_i;
    logic signed [ACC_W-1:0]   prod_d;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          acc_mag;
    t_acc_item                 n_b;

    // Flow control: each stage moves when the one after it has room
    assign en_b       = !r_b_valid || i_acc_take;
    assign en_a       = !r_a_valid || en_b;
    assign o_in_ready = en_a;

    // Error terms
    always_comb begin
        e    = (SPEED_W+1)'(r_a_targ) - (SPEED_W+1)'(r_a_meas);
        e1   = r_last_err[r_a_ch];
        e2   = r_prior_err[r_a_ch];
        de1  = (ERR_W+1)'(e) - (ERR_W+1)'(e1);
        de2  = (ERR_W+2)'(e) - ((ERR_W+2)'(e1) <<< 1) + (ERR_W+2)'(e2);
        kp_s = $signed({1'b0, i_gains.kp});
        ki_s = $signed({1'b0, i_gains.ki});
        kd_s = $signed({1'b0, i_gains.kd});
    end

    // Three products in parallel, then the exact sum
    always_comb begin
        prod_p  = (ACC_W)'(kp_s) * (ACC_W)'(de1);
        prod_i  = (ACC_W)'(ki_s) * (ACC_W)'(e);
        prod_d  = (ACC_W)'(kd_s) * (ACC_W)'(de2);
        acc     = prod_p + prod_i + prod_d;
        acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        n_b.ch  = r_a_ch;
        n_b.neg = acc[ACC_W-1];
        if (acc_mag >= ACC_W'(ACC_LIMIT)) begin
            n_b.mag = MAG_W'(ACC_LIMIT);
        end else begin
            n_b.mag = acc_mag[MAG_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_in_valid;
        end
        if (en_a && i_in_valid) begin
            r_a_ch   <= i_channel;
            r_a_meas <= i_measured_speed;
            r_a_targ <= i_target_speed;
        end
    end

    // Error history shifts as the item leaves this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err[0]  <= '0;
            r_last_err[1]  <= '0;
            r_prior_err[0] <= '0;
            r_prior_err[1] <= '0;
        end else if (r_a_valid && en_b) begin
            r_prior_err[r_a_ch] <= e1;
            r_last_err[r_a_ch]  <= ERR_W'(e);
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
        if (en_b && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_acc_valid = r_b_valid;
    assign o_acc       = r_b;

endmodule

>>> hdl/incpid_drv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incpid_drv
// Scales the PID sum, updates the channel drive with saturation, result reg.
// ----------------------------------------------------------------------------
module incpid_drv (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc_valid,
    output logic                                o_acc_take,
    input  incpid_pkg::t_acc_item               i_acc,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [incpid_pkg::DRIVE_W-1:0]      o_drive_value
);
    import incpid_pkg::*;

    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int SUM_W  = QUOT_W + 2;

    logic [DRIVE_W-1:0] r_drive [2];
    logic               r_o_valid;
    logic [DRIVE_W-1:0] r_o_drive;

    logic               en_o;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic signed [SUM_W-1:0] sum;
    logic [DRIVE_W-1:0] n_drive;

    assign en_o       = !r_o_valid || i_out_ready;
    assign o_acc_take = en_o;

    // Truncating divide by the gain scale: reciprocal multiply on the magnitude
    always_comb begin
        prod = PROD_W'(i_acc.mag) * PROD_W'(DIV_RECIP);
        quot = prod[DIV_SHIFT +: QUOT_W];
    end

    // Add increment to the channel drive and saturate to 0..DRIVE_MAX
    always_comb begin
        if (i_acc.neg) begin
            sum = $signed(SUM_W'(r_drive[i_acc.ch])) - $signed(SUM_W'(quot));
        end else begin
            sum = $signed(SUM_W'(r_drive[i_acc.ch])) + $signed(SUM_W'(quot));
        end
        if (sum < 0) begin
            n_drive = '0;
        end else if (sum > $signed(SUM_W'(DRIVE_MAX))) begin
            n_drive = DRIVE_W'(DRIVE_MAX);
        end else begin
            n_drive = sum[DRIVE_W-1:0];
        end
    end

    // Drive state per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive[0] <= '0;
            r_drive[1] <= '0;
        end else if (i_acc_valid && en_o) begin
            r_drive[i_acc.ch] <= n_drive;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= i_acc_valid;
        end
        if (en_o && i_acc_valid) begin
            r_o_drive <= n_drive;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_drive_value = r_o_drive;

endmodule

>>> hdl/incremental_pid_speed_loop_unit.sv
`timescale 1ns / 1ps
// An item passes the input register, stage register and result register.
// Throughput: one item per cycle while i_out_ready allows; the per-channel
// error history updates as an item leaves the input register, the drive as
// it leaves the stage register, so same-channel items may come back to back.
// Reset: synchronous, active low; gains return to kp=0, ki=500, kd=0 and
// both channels' error history and drive clear to zero.
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_unit
// Two-channel velocity-form PID speed loop with saturated drive output.
// ----------------------------------------------------------------------------
module incremental_pid_speed_loop_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [incpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [incpid_pkg::GAIN_W-1:0]         i_cfg_data,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_channel,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_target_speed,
    // result items
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [incpid_pkg::DRIVE_W-1:0]        o_drive_value
);
    import incpid_pkg::*;

    t_gains    gains;
    logic      acc_valid;
    logic      acc_take;
    t_acc_item acc;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;

    incpid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gains     (gains)
    );

    incpid_err u_err (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_gains          (gains),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_channel        (i_channel),
        .i_measured_speed (i_measured_speed),
        .i_target_speed   (i_target_speed),
        .o_acc_valid      (acc_valid),
        .i_acc_take       (acc_take),
        .o_acc            (acc)
    );

    incpid_drv u_drv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc_valid   (acc_valid),
        .o_acc_take    (acc_take),
        .i_acc         (acc),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_value (o_drive_value)
    );

endmodule

>>> tb/sv/incremental_pid_speed_loop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_checker
// Watches the gain, speed and drive channels of the PID speed loop. It keeps
// its own copy of the gains and of each wheel's error history and drive, and
// it predicts the drive for every accepted speed item. Each accepted drive
// item is then compared with the oldest prediction.
// ----------------------------------------------------------------------------
module incremental_pid_speed_loop_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [incpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [incpid_pkg::GAIN_W-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_channel,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic signed [incpid_pkg::SPEED_W-1:0] i_target_speed,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [incpid_pkg::DRIVE_W-1:0]        i_drive_value,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_drive_count
);
    import incpid_pkg::*;

    // Gains and per-wheel loop state
    logic [GAIN_W-1:0]  kp_milli;
    logic [GAIN_W-1:0]  ki_milli;
    logic [GAIN_W-1:0]  kd_milli;
    longint             err_last [2];
    longint             err_prior [2];
    longint             drive_level [2];

    logic [DRIVE_W-1:0] drive_expected_q [$];

    // Velocity-form update of one wheel; returns the saturated drive
    function automatic logic [DRIVE_W-1:0] step_wheel(
        input logic                      ch,
        input logic signed [SPEED_W-1:0] meas,
        input logic signed [SPEED_W-1:0] tgt
    );
        longint err;
        longint sum;
        longint drv;
        err = longint'(tgt) - longint'(meas);
        sum = longint'(kp_milli) * (err - err_last[ch])
            + longint'(ki_milli) * err
            + longint'(kd_milli) * (err - 2 * err_last[ch] + err_prior[ch]);
        // signed division truncates toward zero
        drv = drive_level[ch] + sum / longint'(GAIN_SCALE);
        if (drv > DRIVE_MAX) drv = DRIVE_MAX;
        if (drv < 0) drv = 0;
        drive_level[ch] = drv;
        err_prior[ch]   = err_last[ch];
        err_last[ch]    = err;
        return drv[DRIVE_W-1:0];
    endfunction

    assign o_pending = drive_expected_q.size();

    // Track all three channels on the rising edge
    always @(posedge i_clk) begin
        logic [DRIVE_W-1:0] exp_drive;
        if (!i_rst_n) begin
            kp_milli = PROP_RESET;
            ki_milli = INTEG_RESET;
            kd_milli = DERIV_RESET;
            for (int w = 0; w < 2; w++) begin
                err_last[w]    = 0;
                err_prior[w]   = 0;
                drive_level[w] = 0;
            end
            drive_expected_q.delete();
            o_fail_count  <= 0;
            o_drive_count <= 0;
        end else begin
            // gain write; unlisted index is ignored
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROP:  kp_milli = i_cfg_data;
                    CFG_INTEG: ki_milli = i_cfg_data;
                    CFG_DERIV: kd_milli = i_cfg_data;
                    default: ;
                endcase
            end
            // speed item: predict
            if (i_in_valid && i_in_ready)
                drive_expected_q.push_back(
                    step_wheel(i_channel, i_measured_speed, i_target_speed));
            // drive item: compare against oldest prediction
            if (i_out_valid && i_out_ready) begin
                o_drive_count <= o_drive_count + 1;
                if (drive_expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] drive item %0d with nothing expected",
                                 $realtime, i_drive_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_drive = drive_expected_q.pop_front();
                    if (i_drive_value !== exp_drive) begin
                        if (o_fail_count < 10)
                            $display("[%0t] drive_value mismatch: expected %0d, got %0d",
                                     $realtime, exp_drive, i_drive_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/incremental_pid_speed_loop_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_unit_tb
// Stimulus for the two-wheel PID speed loop. A directed set drives the error
// to both extremes on wheel 0 and the maximum on wheel 1; random tracking items
// and noise run under several gain settings and three sender/receiver idle
// mixes. The checker beside the block predicts and compares every drive item.
// ----------------------------------------------------------------------------
module incremental_pid_speed_loop_unit_tb;
    import incpid_pkg::*;

    localparam int ITEMS_PER_SETTING = 230;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_PROP;
    logic [GAIN_W-1:0]          i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_channel = 1'b0;
    logic signed [SPEED_W-1:0]  i_measured_speed = '0;
    logic signed [SPEED_W-1:0]  i_target_speed = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [DRIVE_W-1:0]         o_drive_value;

    int fail_count;
    int drives_pending;
    int drive_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent = 0;
    int gain_settings = 1;

    incremental_pid_speed_loop_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_channel        (i_channel),
        .i_measured_speed (i_measured_speed),
        .i_target_speed   (i_target_speed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_value    (o_drive_value)
    );

    incremental_pid_speed_loop_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_channel        (i_channel),
        .i_measured_speed (i_measured_speed),
        .i_target_speed   (i_target_speed),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_drive_value    (o_drive_value),
        .o_fail_count     (fail_count),
        .o_pending        (drives_pending),
        .o_drive_count    (drive_count)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive-side back-pressure
    always @(negedge i_clk)
        i_out_ready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);

    // One gain register write; called at a falling edge
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load all three gains, plus a write to the unused index
    task automatic load_gains(input logic [GAIN_W-1:0] kp, ki, kd);
        write_gain(CFG_PROP, kp);
        write_gain(CFG_INTEG, ki);
        write_gain(CFG_DERIV, kd);
        write_gain(CFG_UNLISTED, GAIN_W'($urandom()));
        gain_settings++;
    endtask

    // One speed item; called at a falling edge, returns at one with valid held
    task automatic send_speed(input logic ch, input logic [SPEED_W-1:0] meas, tgt);
        while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_channel        <= ch;
        i_measured_speed <= meas;
        i_target_speed   <= tgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Let every predicted drive come back, then the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (drives_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly a wheel tracking its target, some raw noise
    task automatic send_random_speed();
        int tgt;
        int meas;
        if ($urandom_range(0, 99) < 70) begin
            tgt  = int'($urandom_range(0, 4000)) - 2000;
            meas = tgt + int'($urandom_range(0, 100)) - 50;
            send_speed(1'($urandom_range(0, 1)), SPEED_W'(meas), SPEED_W'(tgt));
        end else begin
            send_speed(1'($urandom_range(0, 1)), SPEED_W'($urandom()), SPEED_W'($urandom()));
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] gain_set [6][3];
        gain_set = '{'{16'd2000, 16'd500, 16'd1000},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                     '{16'd0, 16'd0, 16'd0},
                     '{16'd1, 16'd1, 16'd1},
                     '{16'hFFFF, 16'd0, 16'hFFFF},
                     '{16'd0, 16'd0, 16'd0}};
        gain_set[5] = '{GAIN_W'($urandom_range(0, 3000)), GAIN_W'($urandom_range(0, 3000)),
                        GAIN_W'($urandom_range(0, 3000))};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset gains: largest error up, then down on wheel 0, wheels interleaved
        send_speed(1'b0, 16'sh8000, 16'sh7FFF);
        send_speed(1'b0, 16'sh8000, 16'sh7FFF);
        send_speed(1'b1, 16'sd0, 16'sd0);
        send_speed(1'b0, 16'sh7FFF, 16'sh8000);
        send_speed(1'b1, 16'sd0, 16'sd10);
        send_speed(1'b1, 16'sd0, 16'sd1);
        send_speed(1'b0, 16'sd100, 16'sd120);
        send_speed(1'b1, 16'sh7FFF, 16'sh7FFF);
        send_speed(1'b1, 16'sh8000, 16'sh8000);
        send_speed(1'b0, 16'sd5, 16'sd3);
        send_speed(1'b1, 16'sd3, 16'sd5);
        wait_idle();

        // Directed, all three terms active
        load_gains(16'd1200, 16'd300, 16'd800);
        send_speed(1'b0, 16'sd0, 16'sd400);
        send_speed(1'b0, 16'sd0, 16'sd400);
        send_speed(1'b0, 16'sd300, 16'sd400);
        send_speed(1'b1, 16'sd0, 16'sd900);
        send_speed(1'b0, 16'sd500, 16'sd400);
        send_speed(1'b1, 16'sd900, 16'sd900);
        send_speed(1'b0, 16'sh7FFF, 16'sh8000);
        send_speed(1'b1, 16'sh8000, 16'sh7FFF);
        send_speed(1'b0, 16'sd0, 16'sd1);
        send_speed(1'b1, 16'sd2, 16'sd0);
        wait_idle();

        // Random: three idle mixes, two gain settings each
        for (int mix = 0; mix < 3; mix++) begin
            tx_idle_pct = (mix == 0) ? 29 : (mix == 1) ? 73 : 0;
            rx_idle_pct = (mix == 0) ? 73 : (mix == 1) ? 29 : 0;
            for (int s = 0; s < 2; s++) begin
                load_gains(gain_set[2*mix+s][0], gain_set[2*mix+s][1],
                           gain_set[2*mix+s][2]);
                repeat (ITEMS_PER_SETTING) send_random_speed();
                wait_idle();
            end
        end

        $display("Summary: %0d speed items over %0d gain settings, %0d drive items checked,",
                 items_sent, gain_settings, drive_count);
        $display("         idle mixes 29/73, 73/29 and 0/0 percent (sender/receiver).");
        if (fail_count == 0 && drives_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
